// ===== hdl/emg_pkg.sv =====
// Shared constants, register indexes and the result item type for the epipolar match gate.
// No dependencies; the front, back and top files refer to this package by scoped names.
package emg_pkg;

  localparam int unsigned TAG_W       = 16;
  localparam int unsigned FOCAL_W     = 24;
  localparam int unsigned NORM_W      = 24;
  localparam int unsigned GVEC_W      = 28;
  localparam int unsigned COST_W      = 32;
  localparam int unsigned THR_W       = 31;
  localparam int unsigned ONE_SHIFT   = 20;
  localparam int unsigned NORM_SHIFT  = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned MID_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH   = 16;
  localparam int unsigned BACK_STAGES = 7;

  localparam logic [IDX_W-1:0] REG_INV_FOCAL_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_INV_FOCAL_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ESS_ROW0    = 3'd4;
  localparam logic [IDX_W-1:0] REG_ESS_ROW1    = 3'd5;
  localparam logic [IDX_W-1:0] REG_ESS_ROW2    = 3'd6;
  localparam logic [IDX_W-1:0] REG_MAX_COST    = 3'd7;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic                     keep;
    logic signed [COST_W-1:0] cost;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== hdl/emg_fifo.sv =====
// Small synchronous first-in first-out queue with show-ahead read data.
// Self-contained; used for the front-to-back queue and the result queue.
module emg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH):0]     level
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH) + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign level   = count_r;
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/emg_front.sv =====
// Front part: accepts match items, centers the four pixel coordinates and queues them.
// Depends on emg_pkg and emg_fifo.
module emg_front #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [emg_pkg::TAG_W-1:0]     in_match_tag,
  input  logic [PIXEL_BITS-1:0]         in_first_x,
  input  logic [PIXEL_BITS-1:0]         in_first_y,
  input  logic [PIXEL_BITS-1:0]         in_second_x,
  input  logic [PIXEL_BITS-1:0]         in_second_y,
  input  logic [PIXEL_BITS-1:0]         center_x,
  input  logic [PIXEL_BITS-1:0]         center_y,
  input  logic                          q_pop,
  output logic                          q_empty,
  output logic [emg_pkg::TAG_W+4*(PIXEL_BITS+1)-1:0] q_data
);

  localparam int unsigned DW = PIXEL_BITS + 1;
  localparam int unsigned QW = emg_pkg::TAG_W + 4 * DW;

  logic signed [DW-1:0] d_fx, d_fy, d_sx, d_sy;
  logic [QW-1:0]        entry;

  // Signed offset from the principal point, one bit wider than the pixel field.
  assign d_fx = $signed({1'b0, in_first_x})  - $signed({1'b0, center_x});
  assign d_fy = $signed({1'b0, in_first_y})  - $signed({1'b0, center_y});
  assign d_sx = $signed({1'b0, in_second_x}) - $signed({1'b0, center_x});
  assign d_sy = $signed({1'b0, in_second_y}) - $signed({1'b0, center_y});
  assign entry = {in_match_tag, d_fx, d_fy, d_sx, d_sy};

  emg_fifo #(
    .WIDTH (QW),
    .DEPTH (emg_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (entry),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty),
    .full    (in_full),
    .level   ()
  );

endmodule

// ===== hdl/emg_back.sv =====
// Back part: seven-stage pipeline that normalizes, applies the matrix and forms the cost.
// Depends on emg_pkg; takes items from the front queue and writes the result queue.
module emg_back #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 18
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     src_empty,
  input  logic [emg_pkg::TAG_W+4*(PIXEL_BITS+1)-1:0] src_data,
  output logic                                     src_pop,
  input  logic [emg_pkg::FOCAL_W-1:0]              inv_focal_x,
  input  logic [emg_pkg::FOCAL_W-1:0]              inv_focal_y,
  input  logic [3*COEF_BITS-1:0]                   ess_row0,
  input  logic [3*COEF_BITS-1:0]                   ess_row1,
  input  logic [3*COEF_BITS-1:0]                   ess_row2,
  input  logic [emg_pkg::THR_W-1:0]                max_cost,
  input  logic [$clog2(emg_pkg::OUT_DEPTH):0]      sink_level,
  output logic                                     res_valid,
  output emg_pkg::result_t                         res
);

  localparam int unsigned DW  = PIXEL_BITS + 1;
  localparam int unsigned PW  = DW + emg_pkg::FOCAL_W + 1;
  localparam int unsigned NW  = emg_pkg::NORM_W;
  localparam int unsigned CF  = COEF_BITS - 3;
  localparam int unsigned EW  = COEF_BITS + NW;
  localparam int unsigned AW  = COEF_BITS + 26;
  localparam int unsigned GW  = emg_pkg::GVEC_W;
  localparam int unsigned QW  = NW + GW;
  localparam int unsigned SW  = QW + 2;
  localparam int unsigned CW  = emg_pkg::COST_W;
  localparam int unsigned TW  = emg_pkg::TAG_W;
  localparam int unsigned NS  = emg_pkg::BACK_STAGES;
  localparam int unsigned LW  = $clog2(emg_pkg::OUT_DEPTH) + 2;
  localparam int unsigned SH1 = emg_pkg::ONE_SHIFT;

  function automatic logic signed [PW-1:0] mul_norm(input logic signed [DW-1:0] d,
                                                     input logic [emg_pkg::FOCAL_W-1:0] inv);
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    a = PW'(d);
    b = PW'($signed({1'b0, inv}));
    return a * b;
  endfunction

  // Round Q.28 to Q.20 (ties up) and clamp to the Q4.20 range.
  function automatic logic signed [NW-1:0] sat_norm(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + PW'(1 << (emg_pkg::NORM_SHIFT - 1))) >>> emg_pkg::NORM_SHIFT;
    if (r[PW-1:NW-1] != {(PW-NW+1){r[PW-1]}}) begin
      return r[PW-1] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}};
    end
    return r[NW-1:0];
  endfunction

  logic [2:0][3*COEF_BITS-1:0] ess;
  assign ess = {ess_row2, ess_row1, ess_row0};

  logic [NS-1:0]   v_r, v_nxt;
  logic [LW-1:0]   occupancy;

  // Issue only when the result queue has room for everything already in flight.
  assign occupancy = LW'($countones(v_r)) + LW'(sink_level);
  assign src_pop   = !src_empty && (occupancy < LW'(emg_pkg::OUT_DEPTH));
  assign v_nxt     = {v_r[NS-2:0], src_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 1: scale the centered offsets by the reciprocal focal lengths.
  logic [TW-1:0]        s1_tag_r;
  logic signed [PW-1:0] s1_pfx_r, s1_pfy_r, s1_psx_r, s1_psy_r;

  always_ff @(posedge clk) begin
    s1_tag_r <= src_data[4*DW +: TW];
    s1_pfx_r <= mul_norm(src_data[3*DW +: DW], inv_focal_x);
    s1_pfy_r <= mul_norm(src_data[2*DW +: DW], inv_focal_y);
    s1_psx_r <= mul_norm(src_data[DW +: DW], inv_focal_x);
    s1_psy_r <= mul_norm(src_data[0 +: DW], inv_focal_y);
  end

  // Stage 2: round and clamp to normalized coordinates.
  logic [TW-1:0]        s2_tag_r;
  logic signed [NW-1:0] s2_fx_r, s2_fy_r, s2_sx_r, s2_sy_r;

  always_ff @(posedge clk) begin
    s2_tag_r <= s1_tag_r;
    s2_fx_r  <= sat_norm(s1_pfx_r);
    s2_fy_r  <= sat_norm(s1_pfy_r);
    s2_sx_r  <= sat_norm(s1_psx_r);
    s2_sy_r  <= sat_norm(s1_psy_r);
  end

  // Stage 3: matrix entries times the first point; the third column multiplies 1.0.
  logic [TW-1:0]               s3_tag_r;
  logic signed [NW-1:0]        s3_sx_r, s3_sy_r;
  logic signed [EW-1:0]        s3_pe0_r [3];
  logic signed [EW-1:0]        s3_pe1_r [3];
  logic signed [COEF_BITS-1:0] s3_e2_r  [3];
  logic signed [EW-1:0]        pe0_nxt  [3];
  logic signed [EW-1:0]        pe1_nxt  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pe0_nxt[i] = EW'($signed(ess[i][0 +: COEF_BITS])) * EW'(s2_fx_r);
      pe1_nxt[i] = EW'($signed(ess[i][COEF_BITS +: COEF_BITS])) * EW'(s2_fy_r);
    end
  end

  always_ff @(posedge clk) begin
    s3_tag_r <= s2_tag_r;
    s3_sx_r  <= s2_sx_r;
    s3_sy_r  <= s2_sy_r;
    for (int i = 0; i < 3; i++) begin
      s3_pe0_r[i] <= pe0_nxt[i];
      s3_pe1_r[i] <= pe1_nxt[i];
      s3_e2_r[i]  <= $signed(ess[i][2*COEF_BITS +: COEF_BITS]);
    end
  end

  // Stage 4: sum each row and round back to Q.20.
  logic [TW-1:0]        s4_tag_r;
  logic signed [NW-1:0] s4_sx_r, s4_sy_r;
  logic signed [GW-1:0] s4_g_r [3];
  logic signed [AW-1:0] acc    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(s3_pe0_r[i]) + AW'(s3_pe1_r[i]) + (AW'(s3_e2_r[i]) <<< SH1)
             + AW'(1 << (CF - 1));
    end
  end

  always_ff @(posedge clk) begin
    s4_tag_r <= s3_tag_r;
    s4_sx_r  <= s3_sx_r;
    s4_sy_r  <= s3_sy_r;
    for (int i = 0; i < 3; i++) begin
      s4_g_r[i] <= acc[i][CF +: GW];
    end
  end

  // Stage 5: second point against the row sums.
  logic [TW-1:0]        s5_tag_r;
  logic signed [QW-1:0] s5_q0_r, s5_q1_r;
  logic signed [GW-1:0] s5_g2_r;

  always_ff @(posedge clk) begin
    s5_tag_r <= s4_tag_r;
    s5_q0_r  <= QW'(s4_sx_r) * QW'(s4_g_r[0]);
    s5_q1_r  <= QW'(s4_sy_r) * QW'(s4_g_r[1]);
    s5_g2_r  <= s4_g_r[2];
  end

  // Stage 6: final sum, round to Q.20, clamp to 32 bits.
  logic [TW-1:0]        s6_tag_r;
  logic signed [CW-1:0] s6_cost_r, cost_nxt;
  logic signed [SW-1:0] sum, sum_sh;

  always_comb begin
    sum    = SW'(s5_q0_r) + SW'(s5_q1_r) + (SW'(s5_g2_r) <<< SH1) + SW'(1 << (SH1 - 1));
    sum_sh = sum >>> SH1;
    if (sum_sh[SW-1:CW-1] != {(SW-CW+1){sum_sh[SW-1]}}) begin
      cost_nxt = sum_sh[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      cost_nxt = sum_sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s6_tag_r  <= s5_tag_r;
    s6_cost_r <= cost_nxt;
  end

  // Stage 7: magnitude against the threshold.
  logic [CW:0]      mag;
  emg_pkg::result_t s7_res_r;

  assign mag = s6_cost_r[CW-1] ? (~{s6_cost_r[CW-1], s6_cost_r} + (CW+1)'(1))
                               : {1'b0, s6_cost_r};

  always_ff @(posedge clk) begin
    s7_res_r.tag  <= s6_tag_r;
    s7_res_r.cost <= s6_cost_r;
    s7_res_r.keep <= (mag < (CW+1)'(max_cost));
  end

  assign res_valid = v_r[NS-1];
  assign res       = s7_res_r;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= LW'(emg_pkg::OUT_DEPTH))
    else $error("back pipeline holds more items than the result queue can take");
`endif

endmodule

// ===== hdl/epipolar_match_gate_top.sv =====
// Top level of the epipolar match gate: configuration registers, front, back and result queue.
// Depends on emg_pkg, emg_fifo, emg_front and emg_back.

// The gate takes one feature match per cycle unless in_full holds it off, and returns one
// result per match, in order. Sustained rate is one item per clock in both directions while
// the consumer keeps popping. An item pushed into the four-entry input queue passes through
// seven pipeline stages (scale by reciprocal focal length, round and clamp, matrix products,
// row sums, second-point products, final sum with clamp, threshold compare) and is then
// written into the sixteen-entry result queue, from which it can be popped. The back
// pipeline never stalls; it only takes an item from the input queue when the result queue
// has room for everything already in flight, so a slow consumer first fills the result
// queue and then the input queue, after which full rises. Configuration writes are always
// ready and take effect at once; write them only while no item is in flight. The center
// point is applied as items enter, so the center registers must be settled before the
// first push that should use them.
module epipolar_match_gate_top #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Match input channel
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [emg_pkg::TAG_W-1:0]      in_match_tag,
  input  logic [PIXEL_BITS-1:0]          in_first_x,
  input  logic [PIXEL_BITS-1:0]          in_first_y,
  input  logic [PIXEL_BITS-1:0]          in_second_x,
  input  logic [PIXEL_BITS-1:0]          in_second_y,
  // Result channel
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [emg_pkg::TAG_W-1:0]      out_tag_out,
  output logic                           out_keep,
  output logic signed [emg_pkg::COST_W-1:0] out_epipolar_cost,
  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [emg_pkg::IDX_W-1:0]      cfg_index,
  input  logic [3*COEF_BITS-1:0]         cfg_wdata
);

  localparam int unsigned DW  = PIXEL_BITS + 1;
  localparam int unsigned MQW = emg_pkg::TAG_W + 4 * DW;
  localparam int unsigned EWR = 3 * COEF_BITS;

  // Configuration registers
  logic [emg_pkg::FOCAL_W-1:0] inv_focal_x_r, inv_focal_y_r;
  logic [PIXEL_BITS-1:0]       center_x_r, center_y_r;
  logic [EWR-1:0]              ess_row0_r, ess_row1_r, ess_row2_r;
  logic [emg_pkg::THR_W-1:0]   max_cost_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_focal_x_r <= '1;
      inv_focal_y_r <= '1;
      center_x_r    <= '0;
      center_y_r    <= '0;
      ess_row0_r    <= '0;
      ess_row1_r    <= '0;
      ess_row2_r    <= '0;
      max_cost_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // Decode the register index; keep only the bits each register holds.
      unique case (cfg_index)
        emg_pkg::REG_INV_FOCAL_X: inv_focal_x_r <= cfg_wdata[emg_pkg::FOCAL_W-1:0];
        emg_pkg::REG_INV_FOCAL_Y: inv_focal_y_r <= cfg_wdata[emg_pkg::FOCAL_W-1:0];
        emg_pkg::REG_CENTER_X:    center_x_r    <= cfg_wdata[PIXEL_BITS-1:0];
        emg_pkg::REG_CENTER_Y:    center_y_r    <= cfg_wdata[PIXEL_BITS-1:0];
        emg_pkg::REG_ESS_ROW0:    ess_row0_r    <= cfg_wdata;
        emg_pkg::REG_ESS_ROW1:    ess_row1_r    <= cfg_wdata;
        emg_pkg::REG_ESS_ROW2:    ess_row2_r    <= cfg_wdata;
        emg_pkg::REG_MAX_COST:    max_cost_r    <= cfg_wdata[emg_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept and center, then hold in the input queue.
  logic           mid_pop, mid_empty;
  logic [MQW-1:0] mid_data;

  emg_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_match_tag (in_match_tag),
    .in_first_x   (in_first_x),
    .in_first_y   (in_first_y),
    .in_second_x  (in_second_x),
    .in_second_y  (in_second_y),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .q_pop        (mid_pop),
    .q_empty      (mid_empty),
    .q_data       (mid_data)
  );

  // Back: the arithmetic pipeline.
  logic                                  res_valid;
  emg_pkg::result_t                      res;
  logic [$clog2(emg_pkg::OUT_DEPTH):0]   out_level;
  logic                                  out_full;

  emg_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .src_empty   (mid_empty),
    .src_data    (mid_data),
    .src_pop     (mid_pop),
    .inv_focal_x (inv_focal_x_r),
    .inv_focal_y (inv_focal_y_r),
    .ess_row0    (ess_row0_r),
    .ess_row1    (ess_row1_r),
    .ess_row2    (ess_row2_r),
    .max_cost    (max_cost_r),
    .sink_level  (out_level),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result queue: decouples the pipeline from the consumer.
  logic [emg_pkg::RESULT_W-1:0] out_word;
  emg_pkg::result_t             out_res;

  emg_fifo #(
    .WIDTH (emg_pkg::RESULT_W),
    .DEPTH (emg_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (out_word),
    .empty   (out_empty),
    .full    (out_full),
    .level   (out_level)
  );

  assign out_res           = out_word;
  assign out_tag_out       = out_res.tag;
  assign out_keep          = out_res.keep;
  assign out_epipolar_cost = out_res.cost;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_full)
    else $error("pipeline result dropped on a full result queue");

  a_keep_not_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_keep) |-> (out_epipolar_cost != {1'b1, {(emg_pkg::COST_W-1){1'b0}}}))
    else $error("negative saturated cost marked as kept");

  a_keep_needs_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_keep) |-> (max_cost_r != '0))
    else $error("item kept with a zero threshold");
`endif

endmodule
